[hw/rtl/bmprle_pkg.sv]
package bmprle_pkg;

    localparam int DISPLAY_WIDTH  = 480;
    localparam int DISPLAY_HEIGHT = 320;

    // column holds 0..width, rows_left holds 0..height
    localparam int COL_W   = $clog2(DISPLAY_WIDTH + 1);
    localparam int ROW_W   = $clog2(DISPLAY_HEIGHT + 1);
    localparam int FIELD_W = 9;
    localparam int COLOR_W = 8;
    localparam int SPANS   = 3;

    localparam logic [COL_W-1:0] WIDTH_C  = COL_W'(DISPLAY_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_C = ROW_W'(DISPLAY_HEIGHT);

    // escape codes following a zero count byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef enum logic [6:0] {
        PH_COUNT  = 7'b0000001,
        PH_INDEX  = 7'b0000010,
        PH_ESCAPE = 7'b0000100,
        PH_ABS    = 7'b0001000,
        PH_PAD    = 7'b0010000,
        PH_DX     = 7'b0100000,
        PH_DY     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic               bg;
        logic [COLOR_W-1:0] color;
        logic [FIELD_W-1:0] rows;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] row;
    } span_t;

    typedef struct packed {
        logic [SPANS-1:0]  valid;
        logic              done;
        span_t [SPANS-1:0] span;
    } span_set_t;

    function automatic span_t make_span(
        input logic [FIELD_W-1:0] row,
        input logic [FIELD_W-1:0] col,
        input logic [FIELD_W-1:0] length,
        input logic [FIELD_W-1:0] rows,
        input logic [COLOR_W-1:0] color,
        input logic               bg
    );
        span_t s;
        s.row    = row;
        s.col    = col;
        s.length = length;
        s.rows   = rows;
        s.color  = color;
        s.bg     = bg;
        return s;
    endfunction

endpackage

[hw/rtl/bmprle_parser.sv]
module bmprle_parser import bmprle_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_accept,
    input  logic [7:0] byte_in,
    output span_set_t  set_out
);

    phase_t           phase_reg, phase_next;
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] rows_left_reg, rows_left_next;
    logic [7:0]       held_count_reg, held_count_next;
    logic [7:0]       absolute_left_reg, absolute_left_next;
    logic             pad_pending_reg, pad_pending_next;
    logic [7:0]       delta_dx_reg, delta_dx_next;

    always_comb begin
        logic [ROW_W-1:0] cur_row;
        logic [COL_W-1:0] room;
        logic [COL_W-1:0] run_len;
        logic [COL_W:0]   sum;
        logic [COL_W-1:0] setx;
        logic [ROW_W-1:0] lines;
        logic [ROW_W-1:0] rows_new;
        logic             do_end;
        logic             do_delta;

        phase_next         = phase_reg;
        column_next        = column_reg;
        rows_left_next     = rows_left_reg;
        held_count_next    = held_count_reg;
        absolute_left_next = absolute_left_reg;
        pad_pending_next   = pad_pending_reg;
        delta_dx_next      = delta_dx_reg;

        set_out       = '0;
        cur_row       = HEIGHT_C - rows_left_reg;
        room          = WIDTH_C - column_reg;
        run_len       = (32'(held_count_reg) < 32'(room)) ? COL_W'(held_count_reg) : room;
        sum           = {1'b0, column_reg} + (COL_W + 1)'(delta_dx_reg);
        do_end        = 1'b0;
        do_delta      = 1'b0;
        setx          = '0;
        lines         = '0;

        if (rows_left_reg != '0) begin
            case (phase_reg)
                PH_INDEX: begin
                    if (column_reg < WIDTH_C && run_len != '0) begin
                        set_out.valid[0] = 1'b1;
                        set_out.span[0]  = make_span(FIELD_W'(cur_row), FIELD_W'(column_reg),
                                                     FIELD_W'(run_len), FIELD_W'(1), byte_in,
                                                     1'b0);
                        column_next = column_reg + run_len;
                    end
                    phase_next = PH_COUNT;
                end
                PH_ESCAPE: begin
                    if (byte_in == ESC_EOL) begin
                        phase_next = PH_COUNT;
                        do_end     = 1'b1;
                        lines      = ROW_W'(1);
                    end else if (byte_in == ESC_EOB) begin
                        phase_next = PH_COUNT;
                        do_end     = 1'b1;
                        lines      = rows_left_reg;
                    end else if (byte_in == ESC_DELTA) begin
                        phase_next = PH_DX;
                    end else begin
                        absolute_left_next = byte_in;
                        pad_pending_next   = byte_in[0];
                        phase_next         = PH_ABS;
                    end
                end
                PH_ABS: begin
                    if (column_reg < WIDTH_C) begin
                        set_out.valid[0] = 1'b1;
                        set_out.span[0]  = make_span(FIELD_W'(cur_row), FIELD_W'(column_reg),
                                                     FIELD_W'(1), FIELD_W'(1), byte_in, 1'b0);
                        column_next = column_reg + COL_W'(1);
                    end
                    if (absolute_left_reg <= 8'd1) begin
                        absolute_left_next = '0;
                        phase_next         = pad_pending_reg ? PH_PAD : PH_COUNT;
                        pad_pending_next   = 1'b0;
                    end else begin
                        absolute_left_next = absolute_left_reg - 8'd1;
                    end
                end
                PH_PAD: begin
                    phase_next = PH_COUNT;
                end
                PH_DX: begin
                    delta_dx_next = byte_in;
                    phase_next    = PH_DY;
                end
                PH_DY: begin
                    phase_next = PH_COUNT;
                    setx  = (sum > {1'b0, WIDTH_C}) ? WIDTH_C : sum[COL_W-1:0];
                    lines = (32'(byte_in) > 32'(rows_left_reg)) ? rows_left_reg
                                                                 : ROW_W'(byte_in);
                    if (lines == '0) do_delta = 1'b1;
                    else do_end = 1'b1;
                end
                default: begin
                    if (byte_in != 8'd0) begin
                        held_count_next = byte_in;
                        phase_next      = PH_INDEX;
                    end else begin
                        phase_next = PH_ESCAPE;
                    end
                end
            endcase
        end

        // delta within the same row: background up to the new column
        if (do_delta) begin
            if (setx > column_reg) begin
                set_out.valid[0] = 1'b1;
                set_out.span[0]  = make_span(FIELD_W'(cur_row), FIELD_W'(column_reg),
                                             FIELD_W'(setx - column_reg), FIELD_W'(1),
                                             '0, 1'b1);
            end
            column_next = setx;
        end

        // close row, skip whole rows, then fill the new row's prefix
        rows_new = rows_left_reg - lines;
        if (do_end) begin
            if (column_reg < WIDTH_C) begin
                set_out.valid[0] = 1'b1;
                set_out.span[0]  = make_span(FIELD_W'(cur_row), FIELD_W'(column_reg),
                                             FIELD_W'(room), FIELD_W'(1), '0, 1'b1);
            end
            if (lines > ROW_W'(1)) begin
                set_out.valid[1] = 1'b1;
                set_out.span[1]  = make_span(FIELD_W'(cur_row + ROW_W'(1)), '0,
                                             FIELD_W'(WIDTH_C), FIELD_W'(lines - ROW_W'(1)),
                                             '0, 1'b1);
            end
            rows_left_next = rows_new;
            if (rows_new == '0) begin
                column_next = '0;
            end else begin
                column_next = setx;
                if (setx != '0) begin
                    set_out.valid[2] = 1'b1;
                    set_out.span[2]  = make_span(FIELD_W'(HEIGHT_C - rows_new), '0,
                                                 FIELD_W'(setx), FIELD_W'(1), '0, 1'b1);
                end
            end
        end

        set_out.done = (rows_left_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_COUNT;
            column_reg        <= '0;
            rows_left_reg     <= HEIGHT_C;
            held_count_reg    <= '0;
            absolute_left_reg <= '0;
            pad_pending_reg   <= 1'b0;
            delta_dx_reg      <= '0;
        end else if (byte_accept) begin
            phase_reg         <= phase_next;
            column_reg        <= column_next;
            rows_left_reg     <= rows_left_next;
            held_count_reg    <= held_count_next;
            absolute_left_reg <= absolute_left_next;
            pad_pending_reg   <= pad_pending_next;
            delta_dx_reg      <= delta_dx_next;
        end
    end

endmodule

[hw/rtl/bmprle_span_queue.sv]
module bmprle_span_queue import bmprle_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  span_set_t set_in,
    input  logic      out_ready,
    output logic      out_valid,
    output span_t     out_span,
    output logic      out_last,
    output logic      out_done,
    output logic      can_load
);

    logic [SPANS-1:0]  valid_reg, valid_next;
    span_t [SPANS-1:0] span_reg;
    logic              done_reg;
    logic [SPANS-1:0]  lowest;
    logic              single;
    logic              pop;

    assign lowest    = valid_reg & ~(valid_reg - SPANS'(1));
    assign single    = (valid_reg != '0) && ((valid_reg & (valid_reg - SPANS'(1))) == '0);
    assign out_valid = (valid_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_last  = single;
    assign out_done  = done_reg;
    // a new byte may land as the final queued span leaves
    assign can_load  = (valid_reg == '0) || (single && out_ready);

    always_comb begin
        out_span = span_reg[0];
        for (int i = SPANS - 1; i >= 0; i--) begin
            if (lowest[i]) out_span = span_reg[i];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) valid_next = set_in.valid;
        else if (pop) valid_next = valid_reg & ~lowest;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= '0;
        else valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            span_reg <= set_in.span;
            done_reg <= set_in.done;
        end
    end

endmodule

[hw/rtl/bmp_rle8_span_decoder.sv]
// bmp rle8 span decoder
// s_ channel: one byte of the rle8 pixel stream per transfer (s_tdata).
// m_ channel: rectangular span writes for a 480 x 320 display filled from
// the bottom row upward; m_tlast marks the last span caused by one byte and
// m_tuser[1] flags spans of the byte that passes the top row. once the image
// is complete further bytes are taken and dropped without output.
// a byte is parsed in the cycle it is accepted and its zero to three spans
// sit in a small output queue; the first span is offered in the cycle after
// the byte transfer and the rest follow one per cycle while m_tready is high.
// throughput is one byte per cycle while each byte gives at most one span
// and m_tready is high; a byte giving more spans holds the input until the
// single span output port has drained the queue to its last span.
// s_tready stays high while the queue is empty or its last span is leaving,
// so a stall on m_tready backs up onto the input combinationally.
// synchronous reset clears the parser to the start of the bottom row and
// empties the queue.
module bmp_rle8_span_decoder import bmprle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [8:0] span_row, [17:9] span_col, [26:18] span_length,
                                   // [35:27] span_rows, [43:36] color_index, [47:44] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] is_background, [1] image_done
);

    logic      accept;
    span_set_t set;
    span_t     span;
    logic      done;

    assign accept = s_tvalid && s_tready;

    bmprle_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (accept),
        .byte_in     (s_tdata),
        .set_out     (set)
    );

    bmprle_span_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .set_in    (set),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_span  (span),
        .out_last  (m_tlast),
        .out_done  (done),
        .can_load  (s_tready)
    );

    assign m_tdata = {4'd0, span.color, span.rows, span.length, span.col, span.row};
    assign m_tuser = {done, span.bg};

endmodule
